// ===== rtl/spcg_pkg.sv =====
// ----------------------------------------------------------------------------
// spcg_pkg - shared types, constants and tables of the peak compressor gain
// Holds the word formats, register codes, preset values and the log/exp ROMs.
// ----------------------------------------------------------------------------
package spcg_pkg;

    localparam int ENV_FRAC_BITS  = 24;
    localparam int DB_TABLE_DEPTH = 1024;
    localparam int ENV_W          = ENV_FRAC_BITS + 1;
    localparam int P_W            = $clog2(ENV_W);
    localparam int IDX_W          = $clog2(DB_TABLE_DEPTH);
    localparam int ROOT_STEPS     = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [63:0] ONE_Q30        = 64'd1073741824;
    localparam logic [63:0] DB_PER_OCT_Q16 = 64'd394566;
    // reciprocal of the dB-per-octave factor, scaled by 2^40
    localparam logic [63:0] RECIP_DB       = (64'd1 << 40) / DB_PER_OCT_Q16;
    localparam logic [63:0] ENV_FLOOR_RAW  =
        ((64'd1 << ENV_FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] ENV_FLOOR      = (ENV_FLOOR_RAW < 64'd1) ? 64'd1 : ENV_FLOOR_RAW;
    localparam logic [15:0] GAIN_UNITY     = 16'd4096;

    // register indexes
    localparam logic [1:0] REG_COMP_LEVEL    = 2'd0;
    localparam logic [1:0] REG_ATTACK_COEF   = 2'd1;
    localparam logic [1:0] REG_RELEASE_COEF  = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // compressor presets
    localparam logic [1:0] LVL_BYPASS = 2'd0;
    localparam logic [1:0] LVL_SOFT   = 2'd1;
    localparam logic [1:0] LVL_MEDIUM = 2'd2;
    localparam logic [1:0] LVL_HARD   = 2'd3;

    localparam logic [1:0] CH_MONO = 2'd1;

    typedef struct packed {
        logic [1:0]  comp_level;
        logic [23:0] attack_coef;
        logic [23:0] release_coef;
        logic [1:0]  channel_count;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic [15:0]        volume_gain;
        logic               restart;
        logic               mono;
        logic               bypass;
        logic [ENV_W-1:0]   level;
    } t_item;

    typedef logic [31:0] t_tab [DB_TABLE_DEPTH];

    // preset threshold below full scale, Q16 dB
    function automatic logic [21:0] thr_q16(input logic [1:0] lvl);
        logic [21:0] v;
        unique case (lvl)
            LVL_SOFT:   v = 22'd18 << 16;
            LVL_MEDIUM: v = 22'd24 << 16;
            LVL_HARD:   v = 22'd30 << 16;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // preset makeup gain, Q16 dB
    function automatic logic [21:0] mk_q16(input logic [1:0] lvl);
        logic [21:0] v;
        unique case (lvl)
            LVL_SOFT:   v = 22'd2 << 16;
            LVL_MEDIUM: v = 22'd4 << 16;
            LVL_HARD:   v = 22'd6 << 16;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of a Q1.30 value in [1,2) as a Q16 fraction, by repeated squaring
    function automatic logic [31:0] log2_q16(input logic [63:0] y_in);
        logic [63:0] y;
        logic [31:0] res;
        y = y_in;
        res = '0;
        for (int b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= 2 * ONE_Q30) begin
                y = y >> 1;
                res[b] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_tab build_log_tab();
        t_tab t;
        logic [63:0] y;
        for (int i = 0; i < DB_TABLE_DEPTH; i++) begin
            y = ONE_Q30 + (64'(i) * ONE_Q30) / DB_TABLE_DEPTH;
            t[i] = log2_q16(y);
        end
        return t;
    endfunction

    function automatic t_tab build_exp_tab();
        t_tab t;
        logic [63:0] roots [ROOT_STEPS];
        logic [63:0] fq;
        logic [63:0] e;
        roots[0] = isqrt64(64'd2 << 60);
        for (int k = 1; k < ROOT_STEPS; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int i = 0; i < DB_TABLE_DEPTH; i++) begin
            fq = (64'(i) << 16) / DB_TABLE_DEPTH;
            e = ONE_Q30;
            for (int k = 0; k < ROOT_STEPS; k++)
                if (fq[15-k]) e = (e * roots[k]) >> 30;
            t[i] = e[31:0];
        end
        return t;
    endfunction

    localparam t_tab LOG_TAB = build_log_tab();
    localparam t_tab EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/spcg_in_if.sv =====
// ----------------------------------------------------------------------------
// spcg_in_if - input frame channel
// Valid/ready channel carrying one PCM frame with its volume gain.
// ----------------------------------------------------------------------------
interface spcg_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [15:0]        volume_gain;
    logic               restart_envelope;

    modport source (output valid, sample_left, sample_right, volume_gain,
                    restart_envelope, input ready);
    modport sink   (input valid, sample_left, sample_right, volume_gain,
                    restart_envelope, output ready);
endinterface

// ===== rtl/spcg_out_if.sv =====
// ----------------------------------------------------------------------------
// spcg_out_if - output frame channel
// Valid/ready channel carrying one gained, saturated PCM frame.
// ----------------------------------------------------------------------------
interface spcg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink   (input valid, out_left, out_right, output ready);
endinterface

// ===== rtl/stereo_peak_compressor_gain.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_compressor_gain - volume and peak compressor gain for PCM frames
// Intake stage, two-frame queue, gain sequencer, APB configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one frame per word: left and right samples, a Q1.15 volume
//   gain and a restart flag that clears the envelope before the frame. o_out
//   returns one word per frame: both samples gained, compressed and clipped.
//   The APB port sets the preset, attack/release coefficients and channel
//   count; write it only while no frame is in flight.
//   With a preset active, the gain sequencer steps each frame through
//   envelope, log ROM, gain reduction, dB-to-log2 divide, exp ROM and
//   multiply; in bypass it goes straight to the multiply. It takes the next
//   frame only once it is done with the last, and that loop sets the rate.
//   Reset clears the envelope, the registers, the queue and the output slot.
//   When the receiver stalls, the finished word holds in the output register,
//   the sequencer waits with the next result, and the queue and intake stage
//   keep accepting until three frames are stacked up.
// ----------------------------------------------------------------------------
module stereo_peak_compressor_gain import spcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spcg_in_if.sink     i_in,
    spcg_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  w_cfg;
    t_item w_front_item;
    logic  w_front_valid;
    logic  w_full;
    logic  w_push;
    t_item w_q_item;
    logic  w_q_valid;
    logic  w_pop;

    // configuration registers
    spcg_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // take in and classify frames
    spcg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (w_cfg),
        .o_item       (w_front_item),
        .o_item_valid (w_front_valid),
        .i_item_ready (!w_full)
    );

    assign w_push = w_front_valid && !w_full;

    // decouple intake from the gain sequencer
    spcg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_valid (w_q_valid)
    );

    // envelope, gain and output register
    spcg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item       (w_q_item),
        .i_item_valid (w_q_valid),
        .o_item_pop   (w_pop),
        .o_out        (o_out)
    );

    // the queue is never popped empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // in mono the right output is always silent
    a_mono_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_cfg.channel_count == CH_MONO) |-> (o_out.out_right == 16'sd0))
        else $error("right output not silent in mono");

    // nothing leaves the block straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

// ===== rtl/spcg_apb.sv =====
// ----------------------------------------------------------------------------
// spcg_apb - configuration registers
// APB-style write/read of the preset, coefficients and channel count.
// ----------------------------------------------------------------------------
module spcg_apb import spcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.comp_level    <= LVL_BYPASS;
            r_cfg.attack_coef   <= '0;
            r_cfg.release_coef  <= '0;
            r_cfg.channel_count <= 2'd2;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_COMP_LEVEL:    r_cfg.comp_level    <= pwdata[1:0];
                REG_ATTACK_COEF:   r_cfg.attack_coef   <= pwdata[23:0];
                REG_RELEASE_COEF:  r_cfg.release_coef  <= pwdata[23:0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COMP_LEVEL:    prdata = {30'd0, r_cfg.comp_level};
            REG_ATTACK_COEF:   prdata = {8'd0, r_cfg.attack_coef};
            REG_RELEASE_COEF:  prdata = {8'd0, r_cfg.release_coef};
            REG_CHANNEL_COUNT: prdata = {30'd0, r_cfg.channel_count};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== rtl/spcg_front.sv =====
// ----------------------------------------------------------------------------
// spcg_front - frame intake and classification
// Accepts a frame, masks the right sample for mono, finds the peak level.
// ----------------------------------------------------------------------------
module spcg_front import spcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spcg_in_if.sink i_in,
    input  t_cfg  i_cfg,
    output t_item o_item,
    output logic  o_item_valid,
    input  logic  i_item_ready
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic        w_mono;
    logic [15:0] w_mag_l;
    logic [15:0] w_mag_r;
    logic [15:0] w_peak;

    assign i_in.ready   = !r_valid || i_item_ready;
    assign o_item       = r_item;
    assign o_item_valid = r_valid;

    always_comb begin
        w_mono  = (i_cfg.channel_count == CH_MONO);
        w_mag_l = i_in.sample_left[15] ? 16'(-i_in.sample_left) : i_in.sample_left;
        w_mag_r = (w_mono || !i_in.sample_right[15]) ?
                  (w_mono ? 16'd0 : i_in.sample_right) : 16'(-i_in.sample_right);
        w_peak  = (w_mag_r > w_mag_l) ? w_mag_r : w_mag_l;
        n_item.sample_left  = i_in.sample_left;
        n_item.sample_right = w_mono ? 16'sd0 : i_in.sample_right;
        n_item.volume_gain  = i_in.volume_gain;
        n_item.restart      = i_in.restart_envelope;
        n_item.mono         = w_mono;
        n_item.bypass       = (i_cfg.comp_level == LVL_BYPASS);
        n_item.level        = ENV_W'(w_peak) << (ENV_FRAC_BITS - 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/spcg_fifo.sv =====
// ----------------------------------------------------------------------------
// spcg_fifo - short queue between intake and gain sequencer
// Two-entry first-in first-out store of classified frames.
// ----------------------------------------------------------------------------
module spcg_fifo import spcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// ===== rtl/spcg_back.sv =====
// ----------------------------------------------------------------------------
// spcg_back - envelope, gain computer and sample gain sequencer
// Steps one frame through envelope, log, gain reduction, exp and multiply.
// ----------------------------------------------------------------------------
module spcg_back import spcg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    input  logic  i_item_valid,
    output logic  o_item_pop,
    spcg_out_if.source o_out
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ENV  = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_LOG  = 4'd3;
    localparam logic [3:0] ST_DB   = 4'd4;
    localparam logic [3:0] ST_OVER = 4'd5;
    localparam logic [3:0] ST_GR   = 4'd6;
    localparam logic [3:0] ST_NET  = 4'd7;
    localparam logic [3:0] ST_QEST = 4'd8;
    localparam logic [3:0] ST_QREM = 4'd9;
    localparam logic [3:0] ST_EXP  = 4'd10;
    localparam logic [3:0] ST_GAIN = 4'd11;
    localparam logic [3:0] ST_MUL  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    localparam int PROD_W = ENV_W + 24;

    logic [3:0]         r_state;
    logic [ENV_W-1:0]   r_env;
    logic               r_out_valid;
    logic signed [15:0] r_out_l;
    logic signed [15:0] r_out_r;
    t_item              r_item;
    logic [PROD_W-1:0]  r_prod;
    logic [31:0]        r_mag_l;
    logic [31:0]        r_mag_r;
    logic [P_W-1:0]     r_p;
    logic [15:0]        r_log;
    logic [23:0]        r_below;
    logic [21:0]        r_over;
    logic [21:0]        r_gr;
    logic [21:0]        r_nmag;
    logic               r_nneg;
    logic [19:0]        r_qest;
    logic [19:0]        r_rem;
    logic signed [7:0]  r_ip;
    logic [31:0]        r_exp;
    logic [15:0]        r_gain;
    logic [47:0]        r_pl;
    logic [47:0]        r_pr;

    logic               w_env_ge;
    logic [ENV_W-1:0]   w_diff;
    logic [23:0]        w_coef;
    logic [ENV_W-1:0]   w_step;
    logic [ENV_W-1:0]   w_env_new;
    logic [ENV_W-1:0]   w_e;
    logic [P_W-1:0]     w_p;
    logic [31:0]        w_norm;
    logic [IDX_W-1:0]   w_log_idx;
    logic [21:0]        w_a;
    logic [47:0]        w_below_full;
    logic [21:0]        w_thr;
    logic [21:0]        w_over;
    logic [55:0]        w_div3;
    logic [21:0]        w_gr;
    logic signed [23:0] w_net;
    logic [39:0]        w_num;
    logic [39:0]        w_rem;
    logic [20:0]        w_q;
    logic signed [22:0] w_l;
    logic [IDX_W-1:0]   w_exp_idx;
    logic signed [8:0]  w_sh;
    logic [32:0]        w_round;
    logic [15:0]        w_gain;
    logic [15:0]        w_abs_l;
    logic [15:0]        w_abs_r;
    logic               w_finish;

    // Truncate the Q-product, restore the sign and clip to 16 bits.
    function automatic logic signed [15:0] sat_out(input logic neg, input logic [47:0] prod);
        logic [20:0] p;
        p = prod[47:27];
        if (neg) begin
            return (p > 21'd32768) ? -16'sd32768 : 16'(21'd0 - p);
        end
        return (p > 21'd32767) ? 16'sd32767 : 16'(p);
    endfunction

    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;
    assign o_item_pop      = (r_state == ST_IDLE) && i_item_valid;
    assign w_finish        = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        // envelope follower
        w_env_ge  = (r_env >= r_item.level);
        w_diff    = w_env_ge ? r_env - r_item.level : r_item.level - r_env;
        w_coef    = w_env_ge ? i_cfg.release_coef : i_cfg.attack_coef;
        w_step    = ENV_W'((r_prod + (PROD_W'(1) << 23)) >> 24);
        w_env_new = w_env_ge ? r_item.level + w_step : r_item.level - w_step;

        // leading one and mantissa index of the floored envelope
        w_e = (r_env < ENV_W'(ENV_FLOOR)) ? ENV_W'(ENV_FLOOR) : r_env;
        w_p = '0;
        for (int k = 0; k < ENV_W; k++)
            if (w_e[k]) w_p = P_W'(k);
        w_norm    = 32'(w_e) << (6'd31 - 6'(w_p));
        w_log_idx = IDX_W'(((31+IDX_W)'(w_norm[30:0]) * (31+IDX_W)'(DB_TABLE_DEPTH)) >> 31);

        // attenuation in dB below full scale
        w_a          = {6'(ENV_FRAC_BITS) - 6'(r_p), 16'h0000} - 22'(r_log);
        w_below_full = 48'(w_a) * 48'(DB_PER_OCT_Q16) + 48'd32768;

        // gain reduction above threshold
        w_thr  = thr_q16(i_cfg.comp_level);
        w_over = (24'(w_thr) > r_below) ? 22'(24'(w_thr) - r_below) : 22'd0;
        w_div3 = (56'(r_over) << 1) * 56'h0_AAAA_AAAB;
        unique case (i_cfg.comp_level)
            LVL_SOFT:   w_gr = r_over >> 1;
            LVL_MEDIUM: w_gr = 22'(w_div3 >> 33);
            LVL_HARD:   w_gr = 22'((24'(r_over) * 24'd3) >> 2);
            default:    w_gr = '0;
        endcase
        w_net = $signed({2'b00, mk_q16(i_cfg.comp_level)}) - $signed({2'b00, r_gr});

        // dB to log2: quotient estimate, remainder, one-step correction
        w_num = (40'(r_nmag) << 16) + 40'(DB_PER_OCT_Q16 >> 1);
        w_rem = w_num - 40'(r_qest) * 40'(DB_PER_OCT_Q16);
        w_q   = 21'(r_qest) + ((r_rem >= 20'(DB_PER_OCT_Q16)) ? 21'd1 : 21'd0);
        w_l   = r_nneg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
        w_exp_idx = IDX_W'((32'(w_l[15:0]) * 32'(DB_TABLE_DEPTH)) >> 16);

        // scale the Q1.30 mantissa into a Q4.12 gain
        w_sh    = 9'sd18 - 9'(r_ip);
        w_round = '0;
        if (w_sh <= 9'sd0) begin
            w_gain = 16'hFFFF;
        end else if (w_sh >= 9'sd32) begin
            w_gain = 16'd0;
        end else begin
            w_round = (33'(r_exp) + (33'd1 << (5'(w_sh) - 5'd1))) >> 5'(w_sh);
            w_gain  = (w_round > 33'd65535) ? 16'hFFFF : 16'(w_round);
        end

        w_abs_l = r_item.sample_left[15]  ? 16'(-r_item.sample_left)  : r_item.sample_left;
        w_abs_r = r_item.sample_right[15] ? 16'(-r_item.sample_right) : r_item.sample_right;
    end

    // control: state, envelope and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_env       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.restart) r_env <= '0;
                        r_state <= ST_ENV;
                    end
                end
                ST_ENV:  r_state <= r_item.bypass ? ST_MUL : ST_UPD;
                ST_UPD: begin
                    r_env   <= w_env_new;
                    r_state <= ST_LOG;
                end
                ST_LOG:  r_state <= ST_DB;
                ST_DB:   r_state <= ST_OVER;
                ST_OVER: r_state <= ST_GR;
                ST_GR:   r_state <= ST_NET;
                ST_NET:  r_state <= ST_QEST;
                ST_QEST: r_state <= ST_QREM;
                ST_QREM: r_state <= ST_EXP;
                ST_EXP:  r_state <= ST_GAIN;
                ST_GAIN: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (w_finish) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_item_pop) r_item <= i_item;
        if (r_state == ST_ENV) begin
            r_prod  <= PROD_W'(w_diff) * PROD_W'(w_coef);
            r_mag_l <= 32'(w_abs_l) * 32'(r_item.volume_gain);
            r_mag_r <= 32'(w_abs_r) * 32'(r_item.volume_gain);
            if (r_item.bypass) r_gain <= GAIN_UNITY;
        end
        if (r_state == ST_LOG) begin
            r_p   <= w_p;
            r_log <= LOG_TAB[w_log_idx][15:0];
        end
        if (r_state == ST_DB)   r_below <= 24'(w_below_full >> 16);
        if (r_state == ST_OVER) r_over  <= w_over;
        if (r_state == ST_GR)   r_gr    <= w_gr;
        if (r_state == ST_NET) begin
            r_nneg <= w_net[23];
            r_nmag <= w_net[23] ? 22'(-w_net) : 22'(w_net);
        end
        if (r_state == ST_QEST) r_qest <= 20'((44'(r_nmag) * 44'(RECIP_DB)) >> 24);
        if (r_state == ST_QREM) r_rem  <= 20'(w_rem);
        if (r_state == ST_EXP) begin
            r_ip  <= 8'(w_l >>> 16);
            r_exp <= EXP_TAB[w_exp_idx];
        end
        if (r_state == ST_GAIN) r_gain <= w_gain;
        if (r_state == ST_MUL) begin
            r_pl <= 48'(r_mag_l) * 48'(r_gain);
            r_pr <= 48'(r_mag_r) * 48'(r_gain);
        end
        if (w_finish) begin
            r_out_l <= sat_out(r_item.sample_left[15], r_pl);
            r_out_r <= r_item.mono ? 16'sd0 : sat_out(r_item.sample_right[15], r_pr);
        end
    end

endmodule

// ===== bench/spcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcg_checker - frame predictor and result comparator
// Watches both frame channels, predicts each output word from its own copy of
// the envelope and registers, and compares it with what the block returns.
// ----------------------------------------------------------------------------
module spcg_checker import spcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spcg_in_if.sink     i_in_mon,
    spcg_out_if.sink    i_out_mon,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_in,
    output int          o_words_out
);

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_frame;

    t_frame             expected_frames [$];
    logic [1:0]         lvl_q;
    logic [23:0]        atk_q;
    logic [23:0]        rel_q;
    logic [1:0]         chans_q;
    logic [ENV_W-1:0]   env_q;
    logic [31:0]        log_rom [DB_TABLE_DEPTH];
    logic [31:0]        exp_rom [DB_TABLE_DEPTH];

    // tables rebuilt here from first principles
    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        logic [63:0] roots [16];
        logic [63:0] y, fq, e;
        logic [31:0] acc;
        roots[0] = int_sqrt(64'd2 << 60);
        for (int k = 1; k < 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < DB_TABLE_DEPTH; i++) begin
            y = 64'd1073741824 + (64'(i) * 64'd1073741824) / DB_TABLE_DEPTH;
            acc = '0;
            for (int b = 15; b >= 0; b--) begin
                y = (y * y) >> 30;
                if (y >= 64'd2147483648) begin
                    y = y >> 1;
                    acc[b] = 1'b1;
                end
            end
            log_rom[i] = acc;
            fq = (64'(i) << 16) / DB_TABLE_DEPTH;
            e = 64'd1073741824;
            for (int k = 0; k < 16; k++)
                if (fq[15-k]) e = (e * roots[k]) >> 30;
            exp_rom[i] = e[31:0];
        end
    end

    function automatic logic [15:0] preset_gain(input logic [1:0] lvl,
                                                input logic [63:0] env_in);
        logic [63:0] e, norm, idx, atten, below, thr, mk, red, lmag, lo, fp, m;
        longint net, l;
        int p, ip, sh;
        e = env_in;
        red = 0;
        p = 0;
        case (lvl)
            LVL_SOFT:   begin thr = 18; mk = 2; end
            LVL_MEDIUM: begin thr = 24; mk = 4; end
            default:    begin thr = 30; mk = 6; end
        endcase
        if (e < ENV_FLOOR) e = ENV_FLOOR;
        while (p < 62 && (e >> (p + 1)) != 0) p++;
        norm = e << (31 - p);
        idx = ((norm - (64'd1 << 31)) * DB_TABLE_DEPTH) >> 31;
        if (idx >= DB_TABLE_DEPTH) idx = DB_TABLE_DEPTH - 1;
        atten = 64'(ENV_FRAC_BITS - p) * 65536 - log_rom[idx];
        below = (atten * 64'd394566 + 32768) >> 16;
        thr = thr << 16;
        // reduction ratio is (n-1)/n with n = level + 1
        if (below < thr) red = (thr - below) * lvl / (lvl + 1);
        net = longint'(mk << 16) - longint'(red);
        lmag = ((net < 0 ? -net : net) * 64'd65536 + 64'd197283) / 64'd394566;
        l = net < 0 ? -longint'(lmag) : longint'(lmag);
        lo = 64'(l + 64 * 65536);
        ip = int'(lo >> 16) - 64;
        fp = lo & 64'hFFFF;
        m = exp_rom[(fp * DB_TABLE_DEPTH) >> 16];
        sh = 18 - ip;
        if (sh <= 0) return 16'hFFFF;
        if (sh >= 63) return 16'h0;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return m > 65535 ? 16'hFFFF : m[15:0];
    endfunction

    function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s,
                                                        input logic [15:0] vol,
                                                        input logic [15:0] g);
        logic [63:0] mag, p;
        mag = s < 0 ? 64'(-32'(s)) : 64'(s);
        p = (mag * vol * g) >> 27;
        if (s < 0) return -(p > 32768 ? 32'd32768 : 32'(p));
        return p > 32767 ? 16'sd32767 : 16'(p);
    endfunction

    task automatic predict_frame();
        logic              mono;
        logic signed [15:0] sl, sr;
        logic [15:0]       g;
        logic [63:0]       pk, mr, lv, env, coef;
        t_frame            f;
        mono = (chans_q == CH_MONO);
        sl = i_in_mon.sample_left;
        sr = mono ? 16'sd0 : i_in_mon.sample_right;
        env = i_in_mon.restart_envelope ? 64'd0 : 64'(env_q);
        g = GAIN_UNITY;
        pk = sl < 0 ? 64'(-32'(sl)) : 64'(sl);
        mr = sr < 0 ? 64'(-32'(sr)) : 64'(sr);
        if (mr > pk) pk = mr;
        if (lvl_q != LVL_BYPASS) begin
            lv = pk << (ENV_FRAC_BITS - 15);
            coef = lv > env ? 64'(atk_q) : 64'(rel_q);
            if (env >= lv) env = lv + (((env - lv) * coef + (64'd1 << 23)) >> 24);
            else           env = lv - (((lv - env) * coef + (64'd1 << 23)) >> 24);
            g = preset_gain(lvl_q, env);
        end
        env_q <= env[ENV_W-1:0];
        f.left = scale_sample(sl, i_in_mon.volume_gain, g);
        f.right = mono ? 16'sd0 : scale_sample(sr, i_in_mon.volume_gain, g);
        expected_frames.push_back(f);
    endtask

    always @(posedge i_clk) begin
        t_frame exp_f;
        if (!i_rst_n) begin
            lvl_q <= LVL_BYPASS;
            atk_q <= '0;
            rel_q <= '0;
            chans_q <= 2'd2;
            env_q <= '0;
            expected_frames.delete();
            o_fail_count <= 0;
            o_words_in <= 0;
            o_words_out <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COMP_LEVEL:   lvl_q <= i_cfg_data[1:0];
                    REG_ATTACK_COEF:  atk_q <= i_cfg_data[23:0];
                    REG_RELEASE_COEF: rel_q <= i_cfg_data[23:0];
                    default:          chans_q <= i_cfg_data[1:0];
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_words_out <= o_words_out + 1;
                if (expected_frames.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected output word %0d/%0d",
                                 i_out_mon.out_left, i_out_mon.out_right);
                end else begin
                    exp_f = expected_frames.pop_front();
                    if (exp_f.left !== i_out_mon.out_left ||
                        exp_f.right !== i_out_mon.out_right) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("word %0d: expected %0d/%0d got %0d/%0d",
                                     o_words_out, exp_f.left, exp_f.right,
                                     i_out_mon.out_left, i_out_mon.out_right);
                    end
                end
            end
            // predict after the pop so a same-edge word is not matched early
            if (i_in_mon.valid && i_in_mon.ready) begin
                o_words_in <= o_words_in + 1;
                predict_frame();
            end
        end
    end

    assign o_pending = expected_frames.size();

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the stereo peak compressor gain
// Sweeps presets, coefficients and channel modes over directed and random
// frames with random gaps on both channels; the checker scores every word.
// ----------------------------------------------------------------------------
module tb_top;
    import spcg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, words_in, words_out;
    int          idle_cycles;
    logic        cfg_we;

    spcg_in_if  in_ch ();
    spcg_out_if out_ch ();

    always #10 i_clk = ~i_clk;

    stereo_peak_compressor_gain u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register write lands at the access edge
    assign cfg_we = psel && penable && pwrite && pready;

    spcg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch.sink),
        .i_out_mon    (out_ch.sink),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (paddr[3:2]),
        .i_cfg_data   (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words_in   (words_in),
        .o_words_out  (words_out)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_left = '0;
        in_ch.sample_right = '0;
        in_ch.volume_gain = '0;
        in_ch.restart_envelope = 1'b0;
        out_ch.ready = 1'b0;
    end

    // receiver: draw a random stall before each word
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 3);
            if (stall == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end
            // hold ready until a word is taken
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    // watchdog: count edges with nothing moving on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d words still due", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial idle_cycles = 0;

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every predicted word is back, plus the block's tail latency
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic signed [15:0] sl, input logic signed [15:0] sr,
                              input logic [15:0] vol, input logic restart);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.sample_left <= sl;
        in_ch.sample_right <= sr;
        in_ch.volume_gain <= vol;
        in_ch.restart_envelope <= restart;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // small levels, full-scale edges and random words, some with loud volumes
    task automatic random_frame();
        logic signed [15:0] sl, sr;
        logic [15:0] vol;
        int r;
        r = $urandom_range(0, 9);
        sl = 16'($urandom);
        sr = 16'($urandom);
        if (r < 4) begin
            sl = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            sr = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
        end else if (r == 4) begin
            sl = 16'sh8000;
            sr = 16'sh7FFF;
        end
        vol = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        send_frame(sl, sr, vol, $urandom_range(0, 19) == 0);
    endtask

    initial begin
        logic [1:0]  lvl;
        logic [23:0] atk, rel;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bypass, each preset, mono and stereo, extremes
        write_reg(REG_ATTACK_COEF, 32'd0);
        write_reg(REG_RELEASE_COEF, 32'hFFFFFF);
        send_frame(16'sh7FFF, 16'sh8000, 16'd32768, 1'b0);
        send_frame(16'sh8000, 16'sd1, 16'hFFFF, 1'b1);
        send_frame(16'sd0, 16'sd0, 16'd0, 1'b0);
        drain();
        for (int lv = 1; lv < 4; lv++) begin
            write_reg(REG_COMP_LEVEL, 32'(lv));
            send_frame(16'sd0, 16'sd0, 16'd32768, 1'b1);
            send_frame(16'sh7FFF, 16'sh8000, 16'd32768, 1'b0);
            send_frame(16'sd100, -16'sd200, 16'hFFFF, 1'b0);
            send_frame(16'sh8000, 16'sh7FFF, 16'd32768, 1'b0);
            send_frame(16'sd5, 16'sd3, 16'd32768, 1'b1);
            drain();
        end
        write_reg(REG_CHANNEL_COUNT, 32'd1);
        send_frame(16'sh8000, 16'sh7FFF, 16'd40000, 1'b0);
        send_frame(-16'sd300, 16'sh8000, 16'd32768, 1'b0);
        drain();
        write_reg(REG_CHANNEL_COUNT, 32'd0);
        send_frame(16'sd50, 16'sh8000, 16'd32768, 1'b0);
        drain();
        write_reg(REG_CHANNEL_COUNT, 32'd3);
        send_frame(16'sd50, 16'sh8000, 16'd32768, 1'b0);
        drain();

        // random phases over presets, coefficients and channel modes
        for (int ph = 0; ph < 10; ph++) begin
            lvl = 2'(ph % 4);
            atk = (ph == 1) ? 24'hFFFFFF : (ph == 2) ? 24'd0 : 24'($urandom);
            rel = (ph == 1) ? 24'd0 : (ph == 2) ? 24'hFFFFFF : 24'($urandom);
            write_reg(REG_COMP_LEVEL, 32'(lvl));
            write_reg(REG_ATTACK_COEF, 32'(atk));
            write_reg(REG_RELEASE_COEF, 32'(rel));
            write_reg(REG_CHANNEL_COUNT, (ph % 3 == 0) ? 32'd1 : 32'd2);
            for (int n = 0; n < 50; n++) begin
                random_frame();
                // let the pipeline empty once mid-phase
                if (n == 25 && ph == 5) drain();
            end
            drain();
        end

        $display("covered %0d frames in, %0d words out, all presets and channel modes",
                 words_in, words_out);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
